// ===== rtl/glr_pkg.sv =====
// Package for the gain and 16-to-15 linear resample unit.
// Holds the shared constants and the lane control struct; no dependencies.
package glr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int PHASE_W  = 4;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Register map (word index)
    localparam logic [APB_AW-3:0] REG_GAIN = 1'b0;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;

    // Gain product is Q15; half-LSB added before the arithmetic shift
    localparam logic signed [32:0] GAIN_ROUND = 33'sd16384;

    // Interpolation: out = floor((2*num + 15) / 30)
    //   z = num + 491527 >= 0, out = floor(z / 15) - 32768
    localparam logic signed [22:0] Z_BIAS = 23'sd491527;
    localparam int Z_W = 20;

    // floor(z/15) = (z * ceil(2^24/15)) >> 24, exact for z < 1198372
    localparam logic [20:0] RECIP_15 = 21'd1118482;
    localparam int RECIP_SHIFT = 24;

    // Control that the top hands to each lane
    typedef struct packed {
        logic                 load_in;   // capture the gain product
        logic                 load_mid;  // capture z, update previous sample
        logic [PHASE_W-1:0]   k;         // phase of the item entering the middle stage
    } lane_ctl_t;

endpackage

// ===== rtl/glr_lane.sv =====
// One channel lane: gain multiply, round and saturate, interpolation and
// the divide by 15 through a reciprocal multiply. Depends on glr_pkg.
module glr_lane
    import glr_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lane_ctl_t                   ctl,
    input  logic [GAIN_W-1:0]           gain,
    input  logic signed [SAMPLE_W-1:0]  sample,
    output logic signed [SAMPLE_W-1:0]  result
);

    logic signed [32:0]         prod_reg, prod_next;
    logic [Z_W-1:0]             z_reg, z_next;
    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;

    logic signed [32:0]         samp_ext, gain_ext, rnd;
    logic signed [SAMPLE_W-1:0] cur;
    logic [4:0]                 w_prev;
    logic [3:0]                 w_cur;
    logic signed [22:0]         term_prev, term_cur, num, z_full;
    logic [40:0]                quot;
    logic [SAMPLE_W-1:0]        q;

    // Stage 1: sample times gain
    always_comb begin
        samp_ext  = 33'(sample);
        gain_ext  = $signed({17'b0, gain});
        prod_next = samp_ext * gain_ext;
    end

    // Stage 2: round half up, saturate, weight prev and cur
    always_comb begin
        rnd = (prod_reg + GAIN_ROUND) >>> 15;
        if (rnd > 33'sd32767) begin
            cur = 16'sh7FFF;
        end else if (rnd < -33'sd32768) begin
            cur = -16'sh8000;
        end else begin
            cur = rnd[SAMPLE_W-1:0];
        end
        w_prev    = 5'd16 - {1'b0, ctl.k};
        w_cur     = ctl.k - 4'd1;
        term_prev = 23'(prev_reg) * $signed({18'b0, w_prev});
        term_cur  = 23'(cur) * $signed({19'b0, w_cur});
        num       = term_prev + term_cur;
        z_full    = num + Z_BIAS;
        z_next    = z_full[Z_W-1:0];
        prev_next = cur;
    end

    // Stage 3: divide by 15, then remove the offset of 32768
    always_comb begin
        quot   = {21'b0, z_reg} * {20'b0, RECIP_15};
        q      = quot[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];
        result = $signed({~q[SAMPLE_W-1], q[SAMPLE_W-2:0]});
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_in) begin
            prod_reg <= prod_next;
        end
        if (ctl.load_mid) begin
            z_reg <= z_next;
        end
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (ctl.load_mid) begin
            prev_reg <= prev_next;
        end
    end

endmodule

// ===== rtl/glr_merge.sv =====
// Output stage: merges the two lane results into one item register.
// Depends on glr_pkg.
module glr_merge
    import glr_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        take,
    input  logic signed [SAMPLE_W-1:0]  left_res,
    input  logic signed [SAMPLE_W-1:0]  right_res,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic signed [SAMPLE_W-1:0]  m_left_out,
    output logic signed [SAMPLE_W-1:0]  m_right_out,
    output logic                        slot_free
);

    logic                       valid_reg, valid_next;
    logic signed [SAMPLE_W-1:0] left_reg, right_reg;

    // Slot opens when empty or drained this cycle
    always_comb begin
        slot_free  = !valid_reg || m_ready;
        valid_next = slot_free ? take : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (slot_free && take) begin
            left_reg  <= left_res;
            right_reg <= right_res;
        end
    end

    assign m_valid     = valid_reg;
    assign m_left_out  = left_reg;
    assign m_right_out = right_reg;

endmodule

// ===== rtl/gain_and_linear_resample_16_to_15_unit.sv =====
// Gain and 16-to-15 linear resample unit, stereo 16-bit frames.
// Path from the accepting edge to result valid: gain product register,
// interpolation register, divide by 15 into the output register. Throughput:
// one item per cycle while m_ready holds; each lane's three-stage pipe sets it.
// Every 16th item (phase 0) produces no result. Synchronous active-low reset
// clears phase, previous frame and valids; gain resets to unity (32768).
module gain_and_linear_resample_16_to_15_unit
    import glr_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_AW-1:0]           paddr,
    input  logic [APB_DW-1:0]           pwdata,
    output logic [APB_DW-1:0]           prdata,
    output logic                        pready,
    // input items
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [SAMPLE_W-1:0]  s_left_sample,
    input  logic signed [SAMPLE_W-1:0]  s_right_sample,
    // result items
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SAMPLE_W-1:0]  m_left_out,
    output logic signed [SAMPLE_W-1:0]  m_right_out
);

    logic [GAIN_W-1:0]          gain_reg, gain_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic                       v1_reg, v1_next;
    logic                       v2_reg, v2_next;
    logic                       emit_reg, emit_next;
    logic                       free1, free2, slot_free, take, cfg_wr;
    lane_ctl_t                  ctl;
    logic signed [SAMPLE_W-1:0] left_res, right_res;

    // APB register file: a single gain register at word index 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        gain_next = gain_reg;
        if (cfg_wr && (paddr[APB_AW-1:2] == REG_GAIN)) begin
            gain_next = pwdata[GAIN_W-1:0];
        end
        prdata = '0;
        if (paddr[APB_AW-1:2] == REG_GAIN) begin
            prdata = {{(APB_DW-GAIN_W){1'b0}}, gain_reg};
        end
    end

    // Pipeline flow: a stage moves when the one after it has room
    always_comb begin
        free2   = !v2_reg || slot_free;
        free1   = !v1_reg || free2;
        s_ready = free1;
        take    = v2_reg && emit_reg;

        v1_next    = free1 ? s_valid : v1_reg;
        v2_next    = free2 ? v1_reg : v2_reg;
        emit_next  = emit_reg;
        phase_next = phase_reg;
        if (free2 && v1_reg) begin
            emit_next  = (phase_reg != '0);
            phase_next = phase_reg + 1'b1;
        end

        ctl.load_in  = free1 && s_valid;
        ctl.load_mid = free2 && v1_reg;
        ctl.k        = phase_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= GAIN_RESET;
            phase_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            emit_reg  <= 1'b0;
        end else begin
            gain_reg  <= gain_next;
            phase_reg <= phase_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            emit_reg  <= emit_next;
        end
    end

    // One lane per channel
    glr_lane u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .gain    (gain_reg),
        .sample  (s_left_sample),
        .result  (left_res)
    );

    glr_lane u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .gain    (gain_reg),
        .sample  (s_right_sample),
        .result  (right_res)
    );

    // Merge both lanes into the result register
    glr_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .left_res    (left_res),
        .right_res   (right_res),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out),
        .slot_free   (slot_free)
    );

    // A new result only appears from an emitting item leaving the last lane stage
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(v2_reg && emit_reg))
        else $error("result appeared without an emitting item");

    // Phase steps by one for each item entering the middle stage
    a_phase_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (free2 && v1_reg) |=> (phase_reg == $past(phase_reg) + 1'b1))
        else $error("phase did not advance with item");

    // Input is refused only while the first stage holds a stalled item
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && m_valid && !m_ready))
        else $error("input stalled with room in the pipe");

    // A phase-zero item never yields a result
    a_phase_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (free2 && v1_reg && (phase_reg == '0)) |=> !emit_reg)
        else $error("phase-zero item marked to emit");

endmodule
